// ===== rtl/pidfd_pkg.sv =====
package pidfd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF = 48;
  localparam int DATA_W        = 32;
  localparam int MS_W          = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;

  // Operation handed to the serial arithmetic unit.
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } ser_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [127:0] x);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    begin
      hi = 128'sd2147483647;
      lo = -128'sd2147483648;
      if (x > hi) sat32 = 32'sh7fffffff;
      else if (x < lo) sat32 = 32'sh80000000;
      else sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/pidfd_serial_unit.sv =====
// Shift-add multiplier and restoring divider on magnitudes, one bit per cycle.
module pidfd_serial_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pidfd_pkg::ser_ctl_t   ctl,
  input  logic [95:0]           opa,
  input  logic [95:0]           opb,
  output pidfd_pkg::ser_sts_t   sts,
  output logic [127:0]          res
);
  import pidfd_pkg::*;

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [95:0]  a_r, a_nxt;
  logic [95:0]  b_r, b_nxt;
  logic [96:0]  rem_try;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_try  = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          // Multiplier bits come from a right shift register, one per cycle.
          if (b_r[0]) acc_nxt = acc_r + {32'd0, a_r};
          a_nxt   = {a_r[94:0], 1'b0};
          b_nxt   = {1'b0, b_r[95:1]};
        end
        default: begin
          // acc holds remainder high, quotient low (64 quotient bits).
          rem_try = {32'd0, acc_r[127:64], a_r[95]} - {33'd0, b_r[63:0]};
          if (!rem_try[96]) begin
            acc_nxt = {rem_try[63:0], acc_r[62:0], 1'b1};
          end else begin
            acc_nxt = {acc_r[126:64], a_r[95], acc_r[62:0], 1'b0};
          end
          a_nxt = {a_r[94:0], 1'b0};
        end
      endcase
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd95) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("start while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");

endmodule

// ===== rtl/pid_filtered_derivative_top.sv =====
// PID controller with a low-pass filtered derivative, signed Q16.16. The first
// item after reset skips the filter. A single shared serial unit handles, one
// bit per cycle, the integral division by 1000, the filter division by 10*ms
// and the three gain multiplications in turn. Each of these is started, shifted
// bit by bit, and then its result is collected. The next item is accepted once
// the result register is free and the sequencer is idle.
module pid_filtered_derivative_top #(
  parameter int FRAC_BITS = pidfd_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = pidfd_pkg::ACC_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_target_value,
  input  logic signed [31:0]  in_measured_value,
  input  logic [15:0]         in_elapsed_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_drive_out,
  output logic signed [31:0]  out_prop_term,
  output logic signed [31:0]  out_integ_term,
  output logic signed [31:0]  out_deriv_term
);
  import pidfd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INTEG = 3'd1;
  localparam logic [2:0] S_FILT  = 3'd2;
  localparam logic [2:0] S_MP    = 3'd3;
  localparam logic [2:0] S_MI    = 3'd4;
  localparam logic [2:0] S_MD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic signed [127:0] AMAX = (128'sd1 <<< (ACC_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] AMIN = -AMAX - 128'sd1;

  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [2:0]  st_r, st_nxt;
  logic        wait_r, wait_nxt;
  logic signed [ACC_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [31:0] prev_r, prev_nxt, slope_r, slope_nxt;
  logic        primed_r, primed_nxt;
  logic signed [31:0] err_r, err_nxt, p_r, p_nxt, i_r, i_nxt, d_r, d_nxt;
  logic [16:0] ms_r, ms_nxt;
  logic        neg_r, neg_nxt;
  logic        ov_r, ov_nxt;
  logic        ov_set;
  logic        ovalid_r, ovalid_nxt;
  logic signed [31:0] o_drv_r, o_drv_nxt, o_p_r, o_p_nxt, o_i_r, o_i_nxt;
  logic signed [31:0] o_d_r, o_d_nxt;

  ser_ctl_t     ctl;
  ser_sts_t     sts;
  logic [95:0]  opa, opb;
  logic [127:0] res;

  logic signed [127:0] err_w, inum, fnum, q_s, m_s, sum, gsrc;
  logic signed [31:0]  gk;
  logic [127:0] mag, rq, mp;
  logic         accept;

  pidfd_serial_unit u_ser (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(opb), .sts(sts), .res(res)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && !ovalid_r;

  always_comb begin
    st_nxt = st_r; wait_nxt = wait_r; integ_nxt = integ_r; prev_nxt = prev_r;
    slope_nxt = slope_r; primed_nxt = primed_r; err_nxt = err_r; ms_nxt = ms_r;
    neg_nxt = neg_r; p_nxt = p_r; i_nxt = i_r; d_nxt = d_r; ov_nxt = ov_r;
    ovalid_nxt = ovalid_r; o_drv_nxt = o_drv_r; o_p_nxt = o_p_r; o_i_nxt = o_i_r;
    o_d_nxt = o_d_r;
    ctl = '0; opa = '0; opb = '0; mag = '0; gsrc = '0; gk = '0; ov_set = 1'b0;
    err_w = 128'(in_target_value) - 128'(in_measured_value);
    inum = 128'(err_r) * $signed({111'd0, ms_r});
    fnum = (128'(err_r) - 128'(prev_r)) * 128'sd1000
         + 128'sd9 * 128'(slope_r) * $signed({111'd0, ms_r});
    // Rounded quotient from the divider: (2|n|+d)/(2d), sign restored.
    rq  = {64'd0, res[63:0]};
    q_s = neg_r ? -$signed(rq) : $signed(rq);
    mp  = res + (128'd1 << (FRAC_BITS - 1));
    m_s = '0;
    if (ov_r || (mp >> (FRAC_BITS + 31)) != 0) ov_set = 1'b1;
    if (ov_set) m_s = neg_r ? -128'sd2147483648 : 128'sd2147483647;
    else m_s = neg_r ? -$signed(mp >> FRAC_BITS) : $signed(mp >> FRAC_BITS);
    sum = 128'(p_r) + 128'(i_r) + 128'(d_r);

    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: if (accept) begin
        err_nxt = sat32(err_w);
        ms_nxt  = (!primed_r || in_elapsed_ms == '0) ? 17'd1 : {1'b0, in_elapsed_ms};
        st_nxt = S_INTEG; wait_nxt = 1'b0;
      end
      S_INTEG: begin
        if (!wait_r) begin
          mag = inum[127] ? -inum : inum;
          neg_nxt = inum[127];
          ctl.start = 1'b1; ctl.op = OP_DIV;
          opa = {mag[94:0], 1'b0} + 96'd1000;
          opb = 96'd2000;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          if (q_s > 0 && 128'(integ_r) > AMAX - q_s) integ_nxt = AMAX[ACC_WIDTH-1:0];
          else if (q_s < 0 && 128'(integ_r) < AMIN - q_s) integ_nxt = AMIN[ACC_WIDTH-1:0];
          else integ_nxt = integ_r + q_s[ACC_WIDTH-1:0];
          if (primed_r) st_nxt = S_FILT;
          else begin
            st_nxt = S_MP; d_nxt = '0;
          end
        end
      end
      S_FILT: begin
        if (!wait_r) begin
          mag = fnum[127] ? -fnum : fnum;
          neg_nxt = fnum[127];
          ctl.start = 1'b1; ctl.op = OP_DIV;
          opa = {mag[94:0], 1'b0} + 96'(ms_r) * 96'd10;
          opb = 96'(ms_r) * 96'd20;
          wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0; slope_nxt = sat32(q_s); st_nxt = S_MP;
        end
      end
      S_MP, S_MI, S_MD: begin
        unique case (st_r)
          S_MP:    begin gsrc = 128'(err_r);   gk = kp_r; end
          S_MI:    begin gsrc = 128'(integ_r); gk = ki_r; end
          default: begin gsrc = primed_r ? 128'(slope_r) : 128'sd0; gk = kd_r; end
        endcase
        if (!wait_r) begin
          mag = gsrc[127] ? -gsrc : gsrc;
          neg_nxt = gsrc[127] ^ gk[31];
          ctl.start = 1'b1; ctl.op = OP_MUL;
          opa = {32'd0, mag[63:0]};
          opb = gk[31] ? (96'd0 - {{64{1'b1}}, gk}) : {64'd0, gk};
          ov_nxt = 1'b0; wait_nxt = 1'b1;
        end else if (sts.done) begin
          wait_nxt = 1'b0;
          unique case (st_r)
            S_MP:    begin p_nxt = m_s[31:0]; st_nxt = S_MI; end
            S_MI:    begin i_nxt = m_s[31:0]; st_nxt = S_MD; end
            default: begin d_nxt = m_s[31:0]; st_nxt = S_OUT; end
          endcase
        end
      end
      default: begin
        o_drv_nxt = sat32(sum); o_p_nxt = p_r; o_i_nxt = i_r; o_d_nxt = d_r;
        ovalid_nxt = 1'b1; prev_nxt = err_r; primed_nxt = 1'b1; st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0;
      st_r <= S_IDLE; wait_r <= 1'b0; integ_r <= '0; prev_r <= '0; slope_r <= '0;
      primed_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KP:  kp_r <= cfg_data;
          REG_KI:  ki_r <= cfg_data;
          REG_KD:  kd_r <= cfg_data;
          default: ;
        endcase
      end
      st_r <= st_nxt; wait_r <= wait_nxt; integ_r <= integ_nxt; prev_r <= prev_nxt;
      slope_r <= slope_nxt; primed_r <= primed_nxt; ovalid_r <= ovalid_nxt;
    end
    err_r <= err_nxt; ms_r <= ms_nxt; neg_r <= neg_nxt; ov_r <= ov_nxt;
    p_r <= p_nxt; i_r <= i_nxt; d_r <= d_nxt;
    o_drv_r <= o_drv_nxt; o_p_r <= o_p_nxt; o_i_r <= o_i_nxt; o_d_r <= o_d_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_drive_out  = o_drv_r;
  assign out_prop_term  = o_p_r;
  assign out_integ_term = o_i_r;
  assign out_deriv_term = o_d_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_primed_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> primed_r) else $error("result without primed");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("second accept");

endmodule

// ===== tb/sv/pid_filtered_derivative_top_tb.sv =====
module pid_filtered_derivative_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidfd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint MAX_CYCLES = 5000000;
  localparam int RANDOM_ITEMS = 200;
  localparam int WINDUP_ITEMS = 80;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] prop;
    logic signed [31:0] integ;
    logic signed [31:0] deriv;
  } pid_terms_t;

  typedef struct {
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    logic [15:0]        ms;
    bit                 typed;
    pid_terms_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_target_value = '0;
  logic signed [31:0] in_measured_value = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_drive_out, out_prop_term, out_integ_term, out_deriv_term;

  pid_filtered_derivative_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Controller state as the block should hold it.
  longint kp, ki, kd;
  longint integral, last_error, slope_filt;
  bit     primed;

  pid_terms_t expected_terms[$];
  int  mismatches = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  longint cycles = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (2 * m + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint scale_gain(longint a, longint g);
    logic signed [127:0] aw, gw, prod;
    logic [127:0] mag;
    bit neg;
    aw = a;
    gw = g;
    prod = aw * gw;
    neg = prod < 0;
    mag = neg ? -prod : prod;
    mag = (mag + (128'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
    if (neg) return (mag > 128'd2147483648) ? -64'sd2147483648 : -longint'(mag);
    return (mag > 128'd2147483647) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic pid_terms_t pid_step(logic signed [31:0] tgt, logic signed [31:0] meas,
                                          logic [15:0] elapsed);
    longint err, ms, inc, slope, p, i, d;
    pid_terms_t r;
    err = sat32(longint'(tgt) - longint'(meas));
    ms = (primed && elapsed != 0) ? longint'(elapsed) : 1;
    slope = 0;
    inc = round_div(err * ms, 1000);
    if (inc > 0 && integral > ACC_MAX - inc) integral = ACC_MAX;
    else if (inc < 0 && integral < ACC_MIN - inc) integral = ACC_MIN;
    else integral += inc;
    if (primed) begin
      slope_filt = sat32(round_div((err - last_error) * 1000 + 9 * slope_filt * ms, 10 * ms));
      slope = slope_filt;
    end
    p = scale_gain(err, kp);
    i = scale_gain(integral, ki);
    d = scale_gain(slope, kd);
    last_error = err;
    primed = 1'b1;
    r.drive = sat32(p + i + d);
    r.prop = p;
    r.integ = i;
    r.deriv = d;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KP: kp = longint'(signed'(data));
      REG_KI: ki = longint'(signed'(data));
      REG_KD: kd = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic write_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_UNUSED, $urandom);
  endtask

  task automatic drain();
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic signed [31:0] tgt, logic signed [31:0] meas, logic [15:0] ms,
                           bit typed = 0, pid_terms_t want = '0);
    pid_terms_t pred;
    @(negedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < send_idle) @(negedge clk);
      @(negedge clk);
    end
    in_target_value = tgt;
    in_measured_value = meas;
    in_elapsed_ms = ms;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = pid_step(tgt, meas, ms);
    expected_terms.push_back(typed ? want : pred);
  endtask

  task automatic release_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h001fffff)) - 32'sh00100000;
    endcase
  endfunction

  function automatic logic [15:0] rand_ms();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return $urandom;
      default: return $urandom_range(50, 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    pid_terms_t want, got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_drive_out, out_prop_term, out_integ_term, out_deriv_term};
      if (expected_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = expected_terms.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  stim_row_t rows[$];

  initial begin
    kp = 0; ki = 0; kd = 0;
    integral = 0; last_error = 0; slope_filt = 0; primed = 0;

    // Directed rows; only the first one, with all gains still zero, is typed in.
    rows = '{
      '{32'sh00010000, 32'sh00000000, 16'd500, 1, '0},
      '{32'sh7fffffff, 32'sh80000000, 16'd0, 0, '0},
      '{32'sh80000000, 32'sh7fffffff, 16'd65535, 0, '0},
      '{32'sh00000000, 32'sh00000000, 16'd1, 0, '0},
      '{32'sh00010000, 32'sh00000000, 16'd1000, 0, '0},
      '{32'sh00000000, 32'sh00010000, 16'd0, 0, '0},
      '{32'sh7fffffff, 32'sh7fffffff, 16'd65535, 0, '0},
      '{32'sh55555555, 32'shaaaaaaaa, 16'h5555, 0, '0},
      '{32'shaaaaaaaa, 32'sh55555555, 16'haaaa, 0, '0},
      '{32'sh00000001, 32'sh00000000, 16'd3, 0, '0},
      '{32'shffffffff, 32'sh00000000, 16'd2, 0, '0},
      '{32'sh00000000, 32'sh00000000, 16'd1, 0, '0},
      '{32'sh00020000, 32'sh00008000, 16'd10, 0, '0},
      '{32'sh00008000, 32'sh00020000, 16'd0, 0, '0},
      '{32'sh7fffffff, 32'sh80000000, 16'd1, 0, '0},
      '{32'sh80000000, 32'sh7fffffff, 16'd1, 0, '0},
      '{32'sh00000000, 32'sh00000000, 16'd65535, 0, '0},
      '{32'sh00001234, 32'shffff0000, 16'd20, 0, '0}
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_idle = 25;
    recv_idle = 77;
    foreach (rows[r]) begin
      if (r == 1) begin
        release_valid();
        drain();
        write_gains(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      end else if (r == 12) begin
        release_valid();
        drain();
        write_gains(32'h00010000, 32'h00008000, 32'h80000000);
      end
      send_item(rows[r].tgt, rows[r].meas, rows[r].ms, rows[r].typed, rows[r].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 25 : (ph == 1) ? 77 : 0;
      recv_idle = (ph == 0) ? 77 : (ph == 1) ? 25 : 0;
      release_valid();
      drain();
      write_gains(rand_gain(), rand_gain(), rand_gain());
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(99) < 3) begin
          release_valid();
          drain();
        end
        send_item(rand_value(), rand_value(), rand_ms());
      end
    end

    // Push the accumulator upward with steps near the largest it can take.
    release_valid();
    drain();
    write_gains(32'h00000001, 32'h00000100, 32'h7fffffff);
    for (int n = 0; n < WINDUP_ITEMS; n++)
      send_item(32'sh7fffffff, rand_value() | 32'sh80000000,
                16'(16'hffff - $urandom_range(3)));
    release_valid();
    drain();
    repeat (1500) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
